[src/nsdq_pkg.sv]
// Package for the noise-shaped dither quantizer.
// Holds the state and result types and the fixed constants; no dependencies.
package nsdq_pkg;

  localparam logic [31:0] LCG_MUL      = 32'h0019_660D;
  localparam logic [31:0] LCG_INC      = 32'h3C6E_F35F;
  localparam logic [31:0] COUNT_FULL   = 32'hFFFF_FFFF;
  localparam logic [4:0]  OUT_BITS_MIN = 5'd8;
  localparam logic [4:0]  OUT_BITS_MAX = 5'd24;
  localparam logic [4:0]  OUT_BITS_RST = 5'd16;

  typedef struct packed {
    logic [31:0] tap0;
    logic [31:0] tap1;
    logic [31:0] tap2;
    logic [31:0] seed;
  } chan_state_t;

  typedef struct packed {
    logic [31:0] clip_total;
    logic [31:0] overshoot_peak;
    logic [31:0] level_peak;
  } clip_stats_t;

  typedef struct packed {
    logic signed [23:0] sample_out;
    logic               clipped;
    logic [31:0]        clip_count;
    logic [30:0]        peak_overshoot;
    logic [30:0]        peak_level;
  } result_t;

endpackage

[src/nsdq_if.sv]
// Item channel interfaces for the noise-shaped dither quantizer.
// Input carries channel and sample; output carries the quantized result. No dependencies.
interface nsdq_in_if;
  logic               valid;
  logic               ready;
  logic               channel;
  logic signed [31:0] sample_in;

  modport source (output valid, output channel, output sample_in, input ready);
  modport sink   (input valid, input channel, input sample_in, output ready);
endinterface

interface nsdq_out_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] sample_out;
  logic               clipped;
  logic [31:0]        clip_count;
  logic [30:0]        peak_overshoot;
  logic [30:0]        peak_level;

  modport source (output valid, output sample_out, output clipped, output clip_count,
                  output peak_overshoot, output peak_level, input ready);
  modport sink   (input valid, input sample_out, input clipped, input clip_count,
                  input peak_overshoot, input peak_level, output ready);
endinterface

[src/nsdq_datapath.sv]
// Single-pass datapath: noise shaping, bias, TPDF dither, clip statistics, quantize.
// Combinational; uses nsdq_pkg types and constants.
module nsdq_datapath
  import nsdq_pkg::*;
#(
  parameter int FRAC_BITS = 28
) (
  input  logic [4:0]  out_bits_i,
  input  logic [31:0] sample_i,
  input  chan_state_t chan_i,
  input  clip_stats_t stats_i,
  output chan_state_t chan_o,
  output clip_stats_t stats_o,
  output result_t     res_o
);

  localparam logic [31:0] ONE_FX = 32'd1 << FRAC_BITS;
  localparam logic [31:0] MAX_FX = ONE_FX - 32'd1;
  localparam logic [31:0] MIN_FX = 32'd0 - ONE_FX;

  logic [4:0]  bits;
  logic [5:0]  scale;
  logic [5:0]  bias_sh;
  logic [31:0] mask;
  logic [31:0] smp;
  logic [31:0] outv;
  logic [31:0] rnd;
  logic [31:0] lvl;
  logic [31:0] s_lim;
  logic [31:0] neg_peak;
  logic [31:0] over;
  logic [31:0] qv;
  logic        clip;

  always_comb begin
    if (out_bits_i < OUT_BITS_MIN) begin
      bits = OUT_BITS_MIN;
    end else if (out_bits_i > OUT_BITS_MAX) begin
      bits = OUT_BITS_MAX;
    end else begin
      bits = out_bits_i;
    end
    scale   = 6'(FRAC_BITS + 1) - {1'b0, bits};
    bias_sh = 6'(FRAC_BITS) - {1'b0, bits};
    mask    = (32'd1 << scale) - 32'd1;

    smp  = sample_i + chan_i.tap0 - chan_i.tap1 + chan_i.tap2;
    rnd  = chan_i.seed * LCG_MUL + LCG_INC;
    outv = smp + (32'd1 << bias_sh) + (rnd & mask) - (chan_i.seed & mask);

    stats_o  = stats_i;
    lvl      = outv;
    s_lim    = smp;
    clip     = 1'b0;
    over     = '0;
    neg_peak = 32'd0 - stats_i.level_peak;
    priority if ($signed(outv) >= $signed(stats_i.level_peak)) begin
      if ($signed(outv) > $signed(MAX_FX)) begin
        clip = 1'b1;
        over = outv - MAX_FX;
        lvl  = MAX_FX;
        if ($signed(smp) > $signed(MAX_FX)) begin
          s_lim = MAX_FX;
        end
      end
      stats_o.level_peak = lvl;
    end else if ($signed(outv) < $signed(neg_peak)) begin
      if ($signed(outv) < $signed(MIN_FX)) begin
        clip = 1'b1;
        over = MIN_FX - outv;
        lvl  = MIN_FX;
        if ($signed(smp) < $signed(MIN_FX)) begin
          s_lim = MIN_FX;
        end
      end
      stats_o.level_peak = 32'd0 - lvl;
    end else begin
      stats_o.level_peak = stats_i.level_peak;
    end

    if (clip) begin
      if (stats_i.clip_total != COUNT_FULL) begin
        stats_o.clip_total = stats_i.clip_total + 32'd1;
      end
      if ($signed(over) > $signed(stats_i.overshoot_peak)) begin
        stats_o.overshoot_peak = over;
      end
    end

    qv = lvl & ~mask;

    chan_o.tap2 = chan_i.tap1;
    chan_o.tap1 = {chan_i.tap0[31], chan_i.tap0[31:1]}
                + {31'd0, chan_i.tap0[31] & chan_i.tap0[0]};
    chan_o.tap0 = s_lim - qv;
    chan_o.seed = rnd;

    res_o.sample_out     = 24'($signed(qv) >>> scale);
    res_o.clipped        = clip;
    res_o.clip_count     = stats_o.clip_total;
    res_o.peak_overshoot = stats_o.overshoot_peak[30:0];
    res_o.peak_level     = stats_o.level_peak[30:0];
  end

endmodule

[src/noise_shaped_dither_quantizer.sv]
// Noise-shaped dither quantizer, top level. Path: input register, then result register (drives
// out_o.valid); a stall on out_o holds both. Throughput: one item per cycle unless out_o stalls,
// set by the combinational shaper/LCG/clip path feeding back into the per-channel state.
// Reset: shaper taps, dither seeds and clip statistics clear to zero; output_bits = 16.
// Uses nsdq_pkg, nsdq_if and nsdq_datapath.
module noise_shaped_dither_quantizer
  import nsdq_pkg::*;
#(
  parameter int FRAC_BITS = 28
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [4:0]    cfg_data_i,
  nsdq_in_if.sink       in_i,
  nsdq_out_if.source    out_o
);

  logic [4:0]  out_bits_q;
  logic        s1_v_q;
  logic        s1_ch_q;
  logic [31:0] s1_smp_q;
  logic        out_v_q;
  result_t     res_q;
  chan_state_t chan_q [2];
  clip_stats_t stats_q;

  chan_state_t chan_d;
  clip_stats_t stats_d;
  result_t     res_d;
  logic        adv;

  assign adv        = s1_v_q && (!out_v_q || out_o.ready);
  assign in_i.ready = !s1_v_q || adv;

  nsdq_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .out_bits_i (out_bits_q),
    .sample_i   (s1_smp_q),
    .chan_i     (chan_q[s1_ch_q]),
    .stats_i    (stats_q),
    .chan_o     (chan_d),
    .stats_o    (stats_d),
    .res_o      (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_bits_q <= OUT_BITS_RST;
    end else if (cfg_we_i) begin
      out_bits_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_v_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_ch_q  <= in_i.channel;
      s1_smp_q <= in_i.sample_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_q[0] <= '0;
      chan_q[1] <= '0;
      stats_q   <= '0;
    end else if (adv) begin
      chan_q[s1_ch_q] <= chan_d;
      stats_q         <= stats_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= 1'b1;
    end else if (out_o.ready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid          = out_v_q;
  assign out_o.sample_out     = res_q.sample_out;
  assign out_o.clipped        = res_q.clipped;
  assign out_o.clip_count     = res_q.clip_count;
  assign out_o.peak_overshoot = res_q.peak_overshoot;
  assign out_o.peak_level     = res_q.peak_level;

`ifndef SYNTHESIS
  a_count_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> stats_q.clip_total >= $past(stats_q.clip_total))
    else $error("clip count decreased");

  a_clip_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && res_q.clipped) |-> (res_q.clip_count != 32'd0))
    else $error("clipped item with zero clip count");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (s1_v_q && out_v_q && !out_o.ready))
    else $error("input stalled without a full pipeline");

  a_stats_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(stats_q))
    else $error("statistics changed without an item");
`endif

endmodule

[bench/tb_noise_shaped_dither_quantizer.sv]
// Self-checking bench for noise_shaped_dither_quantizer: drives samples across output widths,
// predicts shaper, dither and clip statistics per item and checks every result in order.
// Depends on nsdq_pkg, nsdq_if and the quantizer RTL.
`timescale 1ns / 100ps

module tb_noise_shaped_dither_quantizer;
  import nsdq_pkg::*;

  localparam int FRAC = 28;
  localparam logic signed [31:0] MAX_FX = (32'sd1 <<< FRAC) - 32'sd1;
  localparam logic signed [31:0] MIN_FX = -(32'sd1 <<< FRAC);
  localparam int HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PHASE_ITEMS = 100;

  typedef struct packed {
    logic        ch;
    logic [31:0] smp;
  } sample_item_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [4:0]  cfg_data_i;

  nsdq_in_if  in_if ();
  nsdq_out_if out_if ();

  noise_shaped_dither_quantizer DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  sample_item_t pending_samples[$];
  result_t      due_results[$];

  logic [31:0] tap0_q [2];
  logic [31:0] tap1_q [2];
  logic [31:0] tap2_q [2];
  logic [31:0] seed_q [2];
  logic [31:0] clip_total_q;
  logic [31:0] over_peak_q;
  logic [31:0] level_peak_q;
  logic [4:0]  out_bits_q;

  logic in_fire;
  bit   idle_en;
  bit   hold_req;
  int   hold_left;
  int   in_gap;
  int   idle_cycles;
  int   mismatches;
  int   n_items;
  int   n_results;
  int   n_clips;
  int   n_settings;

  always #5 clk_i = ~clk_i;

  function automatic result_t quantize_sample(logic ch, logic [31:0] x);
    int unsigned        bits;
    int unsigned        sbits;
    logic [31:0]        mask;
    logic [31:0]        smp;
    logic [31:0]        outv;
    logic [31:0]        rnd;
    logic [31:0]        over;
    logic signed [31:0] o;
    logic signed [31:0] s;
    logic signed [31:0] pk;
    logic signed [31:0] shifted;
    logic               clip;
    result_t            r;
    bits = out_bits_q;
    if (bits < OUT_BITS_MIN) bits = OUT_BITS_MIN;
    if (bits > OUT_BITS_MAX) bits = OUT_BITS_MAX;
    sbits = FRAC + 1 - bits;
    mask = (32'd1 << sbits) - 32'd1;

    smp = x + tap0_q[ch] - tap1_q[ch] + tap2_q[ch];
    tap2_q[ch] = tap1_q[ch];
    tap1_q[ch] = $signed(tap0_q[ch]) / 2;

    outv = smp + (32'd1 << (FRAC - bits));
    rnd = seed_q[ch] * LCG_MUL + LCG_INC;
    outv = outv + (rnd & mask) - (seed_q[ch] & mask);
    seed_q[ch] = rnd;

    o = outv;
    s = smp;
    pk = level_peak_q;
    clip = 1'b0;
    if (o >= pk) begin
      if (o > MAX_FX) begin
        over = o - MAX_FX;
        clip = 1'b1;
        if (clip_total_q != COUNT_FULL) clip_total_q = clip_total_q + 32'd1;
        if ($signed(over) > $signed(over_peak_q)) over_peak_q = over;
        o = MAX_FX;
        if (s > MAX_FX) s = MAX_FX;
      end
      level_peak_q = o;
    end else if (o < -pk) begin
      if (o < MIN_FX) begin
        over = MIN_FX - o;
        clip = 1'b1;
        if (clip_total_q != COUNT_FULL) clip_total_q = clip_total_q + 32'd1;
        if ($signed(over) > $signed(over_peak_q)) over_peak_q = over;
        o = MIN_FX;
        if (s < MIN_FX) s = MIN_FX;
      end
      level_peak_q = -o;
    end

    outv = o & ~mask;
    tap0_q[ch] = s - outv;
    shifted = $signed(outv) >>> sbits;

    r.sample_out     = shifted[23:0];
    r.clipped        = clip;
    r.clip_count     = clip_total_q;
    r.peak_overshoot = over_peak_q[30:0];
    r.peak_level     = level_peak_q[30:0];
    return r;
  endfunction

  function automatic logic [31:0] pick_sample();
    logic [31:0] v;
    int unsigned kind;
    v = $urandom;
    kind = $urandom_range(0, 99);
    if (kind < 55) begin
      v = {{4{v[28]}}, v[27:0]};
    end else if (kind < 72) begin
      v = ($urandom_range(0, 1) ? 32'h1000_0000 : 32'hF000_0000)
          + 32'($urandom_range(0, 1023)) - 32'd512;
    end else if (kind < 85) begin
      v = {{16{v[15]}}, v[15:0]};
    end
    return v;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t ns: result %0d %s: got %h, expected %h", $time, n_results, what, got, want);
    mismatches++;
  endtask

  // accept, predict and check at the rising edge
  always @(posedge clk_i) begin
    result_t act;
    result_t want;
    if (!rst_ni) begin
      in_fire <= 1'b0;
      idle_cycles <= 0;
    end else begin
      in_fire <= in_if.valid && in_if.ready;
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (in_if.valid && in_if.ready) begin
        due_results.push_back(quantize_sample(in_if.channel, in_if.sample_in));
        n_items++;
      end
      if (out_if.valid && out_if.ready) begin
        act.sample_out     = out_if.sample_out;
        act.clipped        = out_if.clipped;
        act.clip_count     = out_if.clip_count;
        act.peak_overshoot = out_if.peak_overshoot;
        act.peak_level     = out_if.peak_level;
        if (due_results.size() == 0) begin
          report_mismatch("arrived with nothing due", 32'(act.sample_out), 32'd0);
        end else begin
          want = due_results.pop_front();
          if (act.clipped) n_clips++;
          if (act.sample_out !== want.sample_out)
            report_mismatch("sample_out", 32'(act.sample_out), 32'(want.sample_out));
          if (act.clipped !== want.clipped)
            report_mismatch("clipped", 32'(act.clipped), 32'(want.clipped));
          if (act.clip_count !== want.clip_count)
            report_mismatch("clip_count", act.clip_count, want.clip_count);
          if (act.peak_overshoot !== want.peak_overshoot)
            report_mismatch("peak_overshoot", 32'(act.peak_overshoot),
                            32'(want.peak_overshoot));
          if (act.peak_level !== want.peak_level)
            report_mismatch("peak_level", 32'(act.peak_level), 32'(want.peak_level));
        end
        n_results++;
      end
    end
  end

  // drive the next item at the falling edge
  always @(negedge clk_i) begin
    sample_item_t it;
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else if (in_if.valid && !in_fire) begin
      in_if.valid <= 1'b1;
    end else if (in_gap > 0) begin
      in_gap--;
      in_if.valid <= 1'b0;
    end else if (pending_samples.size() != 0) begin
      it = pending_samples.pop_front();
      in_if.valid     <= 1'b1;
      in_if.channel   <= it.ch;
      in_if.sample_in <= it.smp;
      if (idle_en && $urandom_range(0, 7) == 0) in_gap = $urandom_range(1, 12);
    end else begin
      in_if.valid <= 1'b0;
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES - 1;
      out_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 9) == 0) begin
      hold_left = $urandom_range(1, 12) - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("%0t ns: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("** noise_shaped_dither_quantizer: FAILED **");
    $finish;
  end

  task automatic wait_idle();
    @(posedge clk_i);
    while (pending_samples.size() != 0 || in_if.valid || due_results.size() != 0)
      @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_out_bits(logic [4:0] v);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    out_bits_q = v;
    n_settings++;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic push_sample(logic ch, logic [31:0] smp);
    sample_item_t it;
    it.ch  = ch;
    it.smp = smp;
    pending_samples.push_back(it);
  endtask

  task automatic run_phase(logic [4:0] bits, bit with_hold);
    wait_idle();
    write_out_bits(bits);
    @(posedge clk_i);
    for (int i = 0; i < PHASE_ITEMS; i++) push_sample(1'($urandom), pick_sample());
    if (with_hold) hold_req = 1'b1;
  endtask

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_data_i = '0;
    in_if.valid = 1'b0;
    in_if.channel = 1'b0;
    in_if.sample_in = '0;
    out_if.ready = 1'b0;
    idle_en = 1'b1;
    hold_req = 1'b0;
    hold_left = 0;
    in_gap = 0;
    idle_cycles = 0;
    mismatches = 0;
    n_items = 0;
    n_results = 0;
    n_clips = 0;
    n_settings = 1;
    for (int c = 0; c < 2; c++) begin
      tap0_q[c] = '0;
      tap1_q[c] = '0;
      tap2_q[c] = '0;
      seed_q[c] = '0;
    end
    clip_total_q = '0;
    over_peak_q = '0;
    level_peak_q = '0;
    out_bits_q = OUT_BITS_RST;

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // full-scale edges, clipping both ways, then small levels under a high peak
    push_sample(1'b0, 32'h0000_0000);
    push_sample(1'b1, 32'h0000_0001);
    push_sample(1'b0, 32'hFFFF_FFFF);
    push_sample(1'b1, 32'h0FFF_FFFF);
    push_sample(1'b0, 32'h1000_0000);
    push_sample(1'b1, 32'h7FFF_FFFF);
    push_sample(1'b0, 32'h8000_0000);
    push_sample(1'b1, 32'hF000_0000);
    push_sample(1'b0, 32'hEFFF_FFFF);
    push_sample(1'b1, 32'h1000_0001);
    push_sample(1'b0, 32'h0800_0000);
    push_sample(1'b1, 32'hF800_0000);
    push_sample(1'b0, 32'h1234_5678);
    push_sample(1'b1, 32'hEDCB_A987);
    push_sample(1'b0, 32'h5555_5555);
    push_sample(1'b1, 32'hAAAA_AAAA);
    push_sample(1'b0, 32'h0000_0100);
    push_sample(1'b1, 32'hFFFF_FF00);

    run_phase(5'd8, 1'b0);
    run_phase(5'd24, 1'b0);
    run_phase(5'd0, 1'b1);
    run_phase(5'd31, 1'b0);
    run_phase(5'd7, 1'b0);
    run_phase(5'd25, 1'b0);
    run_phase(5'($urandom_range(0, 31)), 1'b0);
    run_phase(5'd12, 1'b0);
    wait_idle();
    idle_en = 1'b0;
    run_phase(5'd20, 1'b0);
    run_phase(OUT_BITS_RST, 1'b0);
    wait_idle();

    $display("Quantized %0d samples over %0d output width settings, %0d results checked.",
             n_items, n_settings, n_results);
    $display("Clip events seen: %0d; mismatches: %0d.", n_clips, mismatches);
    if (mismatches == 0) begin
      $display("** noise_shaped_dither_quantizer: PASSED **");
    end else begin
      $display("** noise_shaped_dither_quantizer: FAILED **");
    end
    $finish;
  end

endmodule

[files.f]
src/nsdq_pkg.sv
src/nsdq_if.sv
src/nsdq_datapath.sv
src/noise_shaped_dither_quantizer.sv
bench/tb_noise_shaped_dither_quantizer.sv
